### hw/rtl/bidirectional_bubble_sorter_top_macros.svh
// Assertion macros shared by the sorter RTL.
`ifndef BIDIRECTIONAL_BUBBLE_SORTER_TOP_MACROS_SVH
`define BIDIRECTIONAL_BUBBLE_SORTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define BBS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sorter assertion failed");
// Next-cycle implication, checked out of reset.
`define BBS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sorter assertion failed");
`else
`define BBS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BBS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/bbs_pkg.sv
// Shared types, microcode encoding and program ROM of the sorter.
`default_nettype none
package bbs_pkg;

  localparam int MAX_ELEMS_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int UPC_W          = 5;

  typedef logic [UPC_W-1:0] upc_t;

  // Datapath operations, one per microword.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_RD_LO,
    OP_CUR_LD,
    OP_RD_UP,
    OP_CS_UP,
    OP_END_UP,
    OP_RD_HI,
    OP_RD_DN,
    OP_CS_DN,
    OP_END_DN,
    OP_EM_INIT,
    OP_EM_RD,
    OP_EMIT,
    OP_CLEAR
  } op_t;

  // Jump conditions; C_NEXT never jumps.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_CLOSE,
    C_LO_GE_HI,
    C_UP_MORE,
    C_DN_MORE,
    C_OUT_BUSY,
    C_EM_MORE
  } cond_t;

  typedef struct packed {
    logic in_rdy;
    op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic close_acc;
    logic lo_ge_hi;
    logic up_more;
    logic dn_more;
    logic out_busy;
    logic em_more;
  } stat_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Program step addresses.
  localparam upc_t S_LOAD    = 5'd0;
  localparam upc_t S_INIT    = 5'd1;
  localparam upc_t S_CHK     = 5'd2;
  localparam upc_t S_UP_RD0  = 5'd3;
  localparam upc_t S_UP_LD   = 5'd4;
  localparam upc_t S_UP_RD   = 5'd5;
  localparam upc_t S_UP_CS   = 5'd6;
  localparam upc_t S_UP_END  = 5'd7;
  localparam upc_t S_DN_CHK  = 5'd8;
  localparam upc_t S_DN_RD0  = 5'd9;
  localparam upc_t S_DN_LD   = 5'd10;
  localparam upc_t S_DN_RD   = 5'd11;
  localparam upc_t S_DN_CS   = 5'd12;
  localparam upc_t S_DN_END  = 5'd13;
  localparam upc_t S_EM_INIT = 5'd14;
  localparam upc_t S_EM_RD   = 5'd15;
  localparam upc_t S_EM_WAIT = 5'd16;
  localparam upc_t S_EM_PUT  = 5'd17;
  localparam upc_t S_EM_END  = 5'd18;

  function automatic uword_t mk(logic rdy, op_t op, cond_t cnd, upc_t tgt);
    uword_t w;
    w.ctrl.in_rdy = rdy;
    w.ctrl.op     = op;
    w.cond        = cnd;
    w.target      = tgt;
    return w;
  endfunction

  // Program ROM.
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      S_LOAD:    w = mk(1'b1, OP_LOAD,    C_NOT_CLOSE, S_LOAD);
      S_INIT:    w = mk(1'b0, OP_INIT,    C_NEXT,      S_LOAD);
      S_CHK:     w = mk(1'b0, OP_NOP,     C_LO_GE_HI,  S_EM_INIT);
      S_UP_RD0:  w = mk(1'b0, OP_RD_LO,   C_NEXT,      S_LOAD);
      S_UP_LD:   w = mk(1'b0, OP_CUR_LD,  C_NEXT,      S_LOAD);
      S_UP_RD:   w = mk(1'b0, OP_RD_UP,   C_NEXT,      S_LOAD);
      S_UP_CS:   w = mk(1'b0, OP_CS_UP,   C_UP_MORE,   S_UP_RD);
      S_UP_END:  w = mk(1'b0, OP_END_UP,  C_NEXT,      S_LOAD);
      S_DN_CHK:  w = mk(1'b0, OP_NOP,     C_LO_GE_HI,  S_EM_INIT);
      S_DN_RD0:  w = mk(1'b0, OP_RD_HI,   C_NEXT,      S_LOAD);
      S_DN_LD:   w = mk(1'b0, OP_CUR_LD,  C_NEXT,      S_LOAD);
      S_DN_RD:   w = mk(1'b0, OP_RD_DN,   C_NEXT,      S_LOAD);
      S_DN_CS:   w = mk(1'b0, OP_CS_DN,   C_DN_MORE,   S_DN_RD);
      S_DN_END:  w = mk(1'b0, OP_END_DN,  C_ALWAYS,    S_CHK);
      S_EM_INIT: w = mk(1'b0, OP_EM_INIT, C_NEXT,      S_LOAD);
      S_EM_RD:   w = mk(1'b0, OP_EM_RD,   C_NEXT,      S_LOAD);
      S_EM_WAIT: w = mk(1'b0, OP_NOP,     C_OUT_BUSY,  S_EM_WAIT);
      S_EM_PUT:  w = mk(1'b0, OP_EMIT,    C_EM_MORE,   S_EM_RD);
      S_EM_END:  w = mk(1'b0, OP_CLEAR,   C_ALWAYS,    S_LOAD);
      default:   w = mk(1'b0, OP_NOP,     C_ALWAYS,    S_LOAD);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/bbs_sequencer.sv
// Microprogram counter, ROM fetch and jump logic of the sorter.
`default_nettype none
module bbs_sequencer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bbs_pkg::stat_t stat,
  output bbs_pkg::ctrl_t     ctrl
);
  import bbs_pkg::*;

  upc_t   upc_r, upc_nxt;
  uword_t uw;
  logic   take;

  assign uw   = ucode(upc_r);
  assign ctrl = uw.ctrl;

  always_comb begin
    unique case (uw.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOT_CLOSE: take = !stat.close_acc;
      C_LO_GE_HI:  take = stat.lo_ge_hi;
      C_UP_MORE:   take = stat.up_more;
      C_DN_MORE:   take = stat.dn_more;
      C_OUT_BUSY:  take = stat.out_busy;
      C_EM_MORE:   take = stat.em_more;
      default:     take = 1'b0;
    endcase
    upc_nxt = take ? uw.target : upc_t'(upc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_LOAD;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bbs_datapath.sv
// Element store, window registers, carry register and output register.
`default_nettype none
`include "bidirectional_bubble_sorter_top_macros.svh"
module bbs_datapath #(
  parameter int MAX_ELEMS  = bbs_pkg::MAX_ELEMS_DEF,
  parameter int DATA_WIDTH = bbs_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bbs_pkg::ctrl_t               ctrl,
  output bbs_pkg::stat_t                    stat,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_value,
  input  wire logic                         in_last_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_sorted_value,
  output logic                              out_last_result,
  output logic                              out_overflow
);
  import bbs_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);

  logic signed [DATA_WIDTH-1:0] mem [MAX_ELEMS];

  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         drop_r, drop_nxt;
  logic [AW-1:0]                lo_r, lo_nxt, hi_r, hi_nxt, j_r, j_nxt;
  logic signed [DATA_WIDTH-1:0] cur_r, cur_nxt;
  logic signed [DATA_WIDTH-1:0] rd_q_r;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_val_r, out_val_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_ovf_r, out_ovf_nxt;

  logic                         we, re;
  logic [AW-1:0]                waddr, raddr;
  logic signed [DATA_WIDTH-1:0] wdata;
  logic                         in_acc, full, last_emit;
  logic [AW-1:0]                j_inc, j_dec;

  assign in_ready  = ctrl.in_rdy;
  assign in_acc    = in_valid && ctrl.in_rdy;
  assign full      = (cnt_r == CW'(MAX_ELEMS));
  assign j_inc     = AW'(j_r + 1'b1);
  assign j_dec     = AW'(j_r - 1'b1);
  assign last_emit = (CW'(CW'(j_r) + 1'b1) == cnt_r);

  assign stat.close_acc = in_acc && in_last_item;
  assign stat.lo_ge_hi  = (lo_r >= hi_r);
  assign stat.up_more   = (j_inc != hi_r);
  assign stat.dn_more   = (j_dec != lo_r);
  assign stat.out_busy  = out_valid_r && !out_ready;
  assign stat.em_more   = !last_emit;

  always_comb begin
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = j_r;
    raddr         = j_r;
    wdata         = cur_r;
    unique case (ctrl.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            we      = 1'b1;
            waddr   = cnt_r[AW-1:0];
            wdata   = in_value;
            cnt_nxt = CW'(cnt_r + 1'b1);
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      OP_INIT: begin
        lo_nxt = '0;
        hi_nxt = AW'(cnt_r - 1'b1);
      end
      OP_RD_LO: begin
        re    = 1'b1;
        raddr = lo_r;
        j_nxt = lo_r;
      end
      OP_CUR_LD: begin
        cur_nxt = rd_q_r;
      end
      OP_RD_UP: begin
        re    = 1'b1;
        raddr = j_inc;
      end
      OP_CS_UP: begin
        // carry the larger value upward
        we    = 1'b1;
        j_nxt = j_inc;
        if (cur_r > rd_q_r) begin
          wdata = rd_q_r;
        end else begin
          wdata   = cur_r;
          cur_nxt = rd_q_r;
        end
      end
      OP_END_UP: begin
        we     = 1'b1;
        hi_nxt = AW'(hi_r - 1'b1);
      end
      OP_RD_HI: begin
        re    = 1'b1;
        raddr = hi_r;
        j_nxt = hi_r;
      end
      OP_RD_DN: begin
        re    = 1'b1;
        raddr = j_dec;
      end
      OP_CS_DN: begin
        // carry the smaller value downward
        we    = 1'b1;
        j_nxt = j_dec;
        if (rd_q_r > cur_r) begin
          wdata = rd_q_r;
        end else begin
          wdata   = cur_r;
          cur_nxt = rd_q_r;
        end
      end
      OP_END_DN: begin
        we     = 1'b1;
        lo_nxt = AW'(lo_r + 1'b1);
      end
      OP_EM_INIT: begin
        j_nxt = '0;
      end
      OP_EM_RD: begin
        re = 1'b1;
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = rd_q_r;
        out_last_nxt  = last_emit;
        out_ovf_nxt   = last_emit && drop_r;
        j_nxt         = j_inc;
      end
      OP_CLEAR: begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    j_r        <= j_nxt;
    cur_r      <= cur_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_val_r;
  assign out_last_result  = out_last_r;
  assign out_overflow     = out_ovf_r;

  `BBS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_ELEMS))
  `BBS_ASSERT_IMP(a_drop_full, clk, rst_n, drop_r, full)
  `BBS_ASSERT_IMP(a_up_window, clk, rst_n, ctrl.op == OP_CS_UP, j_r < hi_r)
  `BBS_ASSERT_IMP(a_dn_window, clk, rst_n, ctrl.op == OP_CS_DN, j_r > lo_r)
  `BBS_ASSERT_IMP(a_emit_free, clk, rst_n, ctrl.op == OP_EMIT, !out_valid_r)
  `BBS_ASSERT_NXT(a_clear_cnt, clk, rst_n, ctrl.op == OP_CLEAR, cnt_r == '0)

endmodule
`default_nettype wire

### hw/rtl/bidirectional_bubble_sorter_top.sv
// Top level of the cocktail shaker sorter: sequencer plus datapath.
`default_nettype none
// Collects up to MAX_ELEMS signed values, one per input beat, and on the beat
// flagged last sorts them ascending with a cocktail shaker sort, then streams
// them out in order with the final beat flagged; out_overflow on that final
// beat reports values dropped because the store was full. The sort is shaped
// by the registered read of the element store: each compare-and-swap step is
// a read followed by a compare-and-write, and the larger (upward pass) or
// smaller (downward pass) value is carried in a register between steps.
// Output beats wait while the sink stalls. Equal values are never swapped,
// so their order is kept. Input is taken only while loading; the next set can
// start loading in the cycle after the last output beat is in the output
// register. Control is a 19-step microprogram in ROM driving the datapath.
module bidirectional_bubble_sorter_top #(
  parameter int MAX_ELEMS  = bbs_pkg::MAX_ELEMS_DEF,
  parameter int DATA_WIDTH = bbs_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_value,
  input  wire logic                         in_last_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_sorted_value,
  output logic                              out_last_result,
  output logic                              out_overflow
);
  import bbs_pkg::*;

  // control word from ROM, status flags back for the jumps
  ctrl_t ctrl;
  stat_t stat;

  bbs_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  bbs_datapath #(
    .MAX_ELEMS  (MAX_ELEMS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_result  (out_last_result),
    .out_overflow     (out_overflow)
  );

endmodule
`default_nettype wire
